// ===== sv/bmpg_pkg.sv =====
package bmpg_pkg;

    localparam int MAX_WIDTH       = 1024;
    localparam int MAX_HEIGHT      = 1024;
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = 8;
    localparam int FIFO_DEPTH      = 8;
    localparam int FIFO_AW         = 3;
    localparam int FIFO_CW         = 4;
    // room kept free for two items in flight plus the one being accepted
    localparam logic [FIFO_CW-1:0] FIFO_ADMIT = FIFO_CW'(FIFO_DEPTH - 6);

    localparam logic [15:0] BMP_MAGIC   = 16'h4D42;
    localparam logic [31:0] HDR_LEN     = 32'd54;
    localparam logic [31:0] FILE_HDR    = 32'd14;
    localparam logic [31:0] DIB_MIN     = 32'd40;
    localparam logic [5:0]  HDR_LASTPOS = 6'd53;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE         = 4'd0,
        ERR_SHORT_HDR    = 4'd1,
        ERR_MAGIC        = 4'd2,
        ERR_BAD_DIB      = 4'd3,
        ERR_UNSUPPORTED  = 4'd4,
        ERR_PAL_LARGE    = 4'd5,
        ERR_PAL_OVERLAP  = 4'd6,
        ERR_PAL_SHORT    = 4'd7,
        ERR_SIZE         = 4'd8,
        ERR_RASTER_SHORT = 4'd9,
        ERR_DISPLAY      = 4'd10
    } t_err;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  pixel_pair;
        logic [18:0] byte_address;
        t_err        error_code;
        logic        final_res;
    } t_res;

    typedef struct packed {
        logic [10:0] display_width;
        logic [10:0] display_height;
    } t_cfg;

    // parser record for one accepted byte
    typedef struct packed {
        logic        valid;
        logic        pix;
        logic        odd;
        logic        is8;
        logic [23:0] rgb;
        logic [18:0] addr;
        logic        ev;
        t_kind       ev_kind;
        t_err        ev_code;
    } t_rec;

    typedef struct packed {
        logic we0;
        logic we1;
        t_res d0;
        t_res d1;
    } t_push;

    function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        logic [15:0] s;
        s = 16'(16'd77 * 16'(r) + 16'd150 * 16'(g) + 16'd29 * 16'(b));
        return s[15:8];
    endfunction

    // (y*15+127)/255 via reciprocal multiply by 257
    function automatic logic [3:0] gray4(input logic [7:0] y);
        logic [11:0] v;
        logic [19:0] p;
        v = 12'(12'd15 * 12'(y) + 12'd128);
        p = 20'(20'(v) * 20'd257);
        return p[19:16];
    endfunction

endpackage

// ===== sv/bmp_to_gray4_stream_decoder.sv =====
// Path: each accepted byte goes through the parser register and the luminance register;
// its results are then written into the output queue, from which they transfer.
// Throughput: one byte per cycle; input is held off while more than two
// results wait in the 8-entry output queue. A byte yields up to two results.
// Reset: synchronous, active low; clears parser and queue state and the
// display registers. Palette memory is not cleared.
module bmp_to_gray4_stream_decoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bmpg_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output bmpg_pkg::t_res  o_data,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [10:0]     i_cfg_data
);
    import bmpg_pkg::*;

    t_cfg               r_cfg;
    t_rec               rec;
    t_push              push;
    logic [2:0]         pal_we;
    logic [7:0]         pal_waddr, pal_wdata, pal_raddr;
    logic [7:0]         pal_r, pal_g, pal_b;
    logic [FIFO_CW-1:0] fifo_count;
    logic               accept;

    assign o_ready = (fifo_count <= FIFO_ADMIT);
    assign accept  = i_valid && o_ready;

    // display registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_cfg.display_width  <= i_cfg_data;
                CFG_HEIGHT: r_cfg.display_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bmpg_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data      (i_data),
        .i_cfg       (r_cfg),
        .o_rec       (rec),
        .o_pal_we    (pal_we),
        .o_pal_waddr (pal_waddr),
        .o_pal_wdata (pal_wdata),
        .o_pal_raddr (pal_raddr)
    );

    bmpg_ram #(.WIDTH(8), .DEPTH(PALETTE_ENTRIES)) u_pal_b (
        .i_clk(i_clk), .i_we(pal_we[0]), .i_waddr(pal_waddr), .i_wdata(pal_wdata),
        .i_raddr(pal_raddr), .o_rdata(pal_b)
    );

    bmpg_ram #(.WIDTH(8), .DEPTH(PALETTE_ENTRIES)) u_pal_g (
        .i_clk(i_clk), .i_we(pal_we[1]), .i_waddr(pal_waddr), .i_wdata(pal_wdata),
        .i_raddr(pal_raddr), .o_rdata(pal_g)
    );

    bmpg_ram #(.WIDTH(8), .DEPTH(PALETTE_ENTRIES)) u_pal_r (
        .i_clk(i_clk), .i_we(pal_we[2]), .i_waddr(pal_waddr), .i_wdata(pal_wdata),
        .i_raddr(pal_raddr), .o_rdata(pal_r)
    );

    bmpg_gray u_gray (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rec     (rec),
        .i_pal_rgb ({pal_r, pal_g, pal_b}),
        .o_push    (push)
    );

    bmpg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .o_count (fifo_count)
    );

endmodule

// ===== sv/bmpg_ram.sv =====
module bmpg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/bmpg_parser.sv =====
module bmpg_parser (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  bmpg_pkg::t_in          i_data,
    input  bmpg_pkg::t_cfg         i_cfg,
    output bmpg_pkg::t_rec         o_rec,
    output logic [2:0]             o_pal_we,
    output logic [7:0]             o_pal_waddr,
    output logic [7:0]             o_pal_wdata,
    output logic [7:0]             o_pal_raddr
);
    import bmpg_pkg::*;

    typedef enum logic [1:0] {PH_HEADER, PH_PRE, PH_RASTER, PH_WAIT} t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [15:0] r_magic, n_magic, r_planes, n_planes, r_bpp, n_bpp;
    logic [31:0] r_offs, n_offs, r_dib, n_dib, r_iw, n_iw, r_ih, n_ih;
    logic [31:0] r_comp, n_comp, r_colors, n_colors;
    logic        r_bu, n_bu;
    logic [8:0]  r_pcount, n_pcount;
    logic [32:0] r_pal_begin, n_pal_begin;
    logic [33:0] r_pal_end, n_pal_end;
    logic [11:0] r_stride, n_stride;
    logic [10:0] r_row, n_row, r_col, n_col;
    logic [11:0] r_bir, n_bir;
    logic [1:0]  r_cpart, n_cpart;
    logic [15:0] r_pc, n_pc;
    logic [18:0] r_row_base, n_row_base;
    logic [20:0] r_base_top;
    t_rec        n_rec;

    logic [7:0]  b;
    logic [5:0]  p6;
    logic [1:0]  k4;
    logic        disp_bad, is8;
    logic [10:0] dw, dh;
    logic [18:0] half;
    logic [31:0] h_abs;
    logic        h_bu;
    logic [32:0] pb;
    logic [8:0]  n_ent;
    logic [33:0] pe;
    logic [14:0] wbits;
    logic [15:0] wround;
    logic [32:0] k_pal;
    logic [11:0] bir1;
    logic [11:0] row1;

    assign b    = i_data.data_byte;
    assign p6   = r_pos[5:0];
    assign k4   = r_pos[1:0] + 2'd2;
    assign dw   = i_cfg.display_width;
    assign dh   = i_cfg.display_height;
    assign half = {9'd0, dw[10:1]};
    assign is8  = (r_bpp == 16'd8);
    assign disp_bad = (dw == 11'd0) || dw[0] || (dw > 11'(MAX_WIDTH)) ||
                      (dh == 11'd0) || (dh > 11'(MAX_HEIGHT));

    // header derived values, used when the header completes, and the palette byte offset
    always_comb begin
        if (r_ih[31]) begin
            h_abs = ~r_ih + 32'd1;
            h_bu  = 1'b0;
        end else begin
            h_abs = r_ih;
            h_bu  = (r_ih != 32'd0);
        end
        pb     = 33'(r_dib) + 33'(FILE_HDR);
        n_ent  = (r_colors == 32'd0) ? 9'd256 : r_colors[8:0];
        pe     = 34'(pb) + 34'({n_ent, 2'b00});
        wbits  = is8 ? 15'({dw, 3'b000}) : 15'(15'({dw, 4'b0000}) + 15'({dw, 3'b000}));
        wround = 16'(16'(wbits) + 16'd31);
        k_pal  = {1'b0, r_pos} - r_pal_begin;
    end

    always_comb begin
        n_phase = r_phase;  n_pos = r_pos;  n_magic = r_magic;  n_planes = r_planes;
        n_bpp = r_bpp;  n_offs = r_offs;  n_dib = r_dib;  n_iw = r_iw;  n_ih = r_ih;
        n_comp = r_comp;  n_colors = r_colors;  n_bu = r_bu;  n_pcount = r_pcount;
        n_pal_begin = r_pal_begin;  n_pal_end = r_pal_end;  n_stride = r_stride;
        n_row = r_row;  n_col = r_col;  n_bir = r_bir;  n_cpart = r_cpart;  n_pc = r_pc;
        n_row_base = r_row_base;
        n_rec = '0;
        n_rec.valid = i_accept;
        n_rec.is8 = is8;
        n_rec.ev_kind = KIND_DONE;
        n_rec.ev_code = ERR_NONE;
        o_pal_we = 3'b000;
        o_pal_waddr = k_pal[9:2];
        o_pal_wdata = b;
        o_pal_raddr = b;
        bir1 = 12'(r_bir + 12'd1);
        row1 = 12'(12'(r_row) + 12'd1);

        if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    // capture header fields, little endian
                    if (p6 <= 6'd1)                    n_magic[8*r_pos[0] +: 8] = b;
                    if (p6 >= 6'd10 && p6 <= 6'd13)    n_offs[8*k4 +: 8] = b;
                    if (p6 >= 6'd14 && p6 <= 6'd17)    n_dib[8*k4 +: 8] = b;
                    if (p6 >= 6'd18 && p6 <= 6'd21)    n_iw[8*k4 +: 8] = b;
                    if (p6 >= 6'd22 && p6 <= 6'd25)    n_ih[8*k4 +: 8] = b;
                    if (p6 >= 6'd26 && p6 <= 6'd27)    n_planes[8*r_pos[0] +: 8] = b;
                    if (p6 >= 6'd28 && p6 <= 6'd29)    n_bpp[8*r_pos[0] +: 8] = b;
                    if (p6 >= 6'd30 && p6 <= 6'd33)    n_comp[8*k4 +: 8] = b;
                    if (p6 >= 6'd46 && p6 <= 6'd49)    n_colors[8*k4 +: 8] = b;
                    if (p6 == 6'd0 && disp_bad) begin
                        n_rec.ev = 1'b1;  n_rec.ev_kind = KIND_ERROR;
                        n_rec.ev_code = ERR_DISPLAY;  n_phase = PH_WAIT;
                    end else if (p6 == HDR_LASTPOS) begin
                        n_rec.ev_kind = KIND_ERROR;
                        n_phase = PH_WAIT;
                        n_rec.ev = 1'b1;
                        if (r_ih[31] || r_ih != 32'd0) n_bu = h_bu;
                        n_ih = h_abs;
                        priority if (disp_bad) begin
                            n_rec.ev_code = ERR_DISPLAY;
                        end else if (r_magic != BMP_MAGIC) begin
                            n_rec.ev_code = ERR_MAGIC;
                        end else if ({1'b0, r_offs} < pb || r_dib < DIB_MIN) begin
                            n_rec.ev_code = ERR_BAD_DIB;
                        end else if (r_iw[31] || r_iw == 32'd0 || r_planes != 16'd1 ||
                                     (r_bpp != 16'd8 && r_bpp != 16'd24) ||
                                     r_comp != 32'd0) begin
                            n_rec.ev_code = ERR_UNSUPPORTED;
                        end else if (is8 && r_colors > 32'(PALETTE_ENTRIES)) begin
                            n_rec.ev_code = ERR_PAL_LARGE;
                        end else if (is8 && pe > 34'(r_offs)) begin
                            n_rec.ev_code = ERR_PAL_OVERLAP;
                        end else if (r_iw != 32'(dw) || h_abs != 32'(dh)) begin
                            n_rec.ev_code = ERR_SIZE;
                        end else begin
                            n_rec.ev = 1'b0;
                            n_rec.ev_kind = KIND_DONE;
                            n_pal_begin = pb;
                            n_pal_end = is8 ? pe : 34'(pb);
                            n_pcount = is8 ? n_ent : 9'd0;
                            n_stride = 12'({wround[15:5], 2'b00});
                            n_row_base = h_bu ? r_base_top[18:0] : 19'd0;
                            n_phase = (r_offs == HDR_LEN) ? PH_RASTER : PH_PRE;
                        end
                    end
                end
                PH_PRE: begin
                    // load palette bytes blue, green, red; skip the fourth
                    if (is8 && {1'b0, r_pos} >= r_pal_begin &&
                        {2'b00, r_pos} < r_pal_end) begin
                        unique case (k_pal[1:0])
                            2'd0:    o_pal_we = 3'b001;
                            2'd1:    o_pal_we = 3'b010;
                            2'd2:    o_pal_we = 3'b100;
                            default: o_pal_we = 3'b000;
                        endcase
                    end
                    if (33'(r_pos) + 33'd1 == 33'(r_offs)) n_phase = PH_RASTER;
                end
                PH_RASTER: begin
                    if (is8) begin
                        if (r_bir < 12'(dw)) n_rec.pix = 1'b1;
                        o_pal_raddr = ({1'b0, b} >= r_pcount) ? 8'(r_pcount - 9'd1) : b;
                    end else if (r_bir < 12'(12'({dw, 1'b0}) + 12'(dw))) begin
                        unique case (r_cpart)
                            2'd0: begin
                                n_pc = {8'd0, b};  n_cpart = 2'd1;
                            end
                            2'd1: begin
                                n_pc = {b, r_pc[7:0]};  n_cpart = 2'd2;
                            end
                            default: begin
                                n_rec.pix = 1'b1;  n_cpart = 2'd0;
                            end
                        endcase
                    end
                    n_rec.rgb = {b, r_pc[15:8], r_pc[7:0]};
                    if (n_rec.pix) begin
                        n_rec.odd  = r_col[0];
                        n_rec.addr = 19'(r_row_base + 19'(r_col[10:1]));
                        n_col = 11'(r_col + 11'd1);
                    end
                    n_bir = bir1;
                    // row end: drop padding, step the row base
                    if (bir1 >= r_stride) begin
                        n_bir = 12'd0;  n_col = 11'd0;  n_cpart = 2'd0;
                        n_row = row1[10:0];
                        n_row_base = r_bu ? 19'(r_row_base - half) : 19'(r_row_base + half);
                        if (row1 >= 12'(dh)) begin
                            n_rec.ev = 1'b1;  n_rec.ev_kind = KIND_DONE;
                            n_rec.ev_code = ERR_NONE;  n_phase = PH_WAIT;
                        end
                    end
                end
                default: ;
            endcase

            if (i_data.last_byte) begin
                if (n_phase != PH_WAIT) begin
                    n_rec.ev = 1'b1;  n_rec.ev_kind = KIND_ERROR;
                    if (n_phase == PH_HEADER) n_rec.ev_code = ERR_SHORT_HDR;
                    else if (n_phase == PH_PRE && is8 &&
                             34'(r_pos) + 34'd1 < n_pal_end) n_rec.ev_code = ERR_PAL_SHORT;
                    else n_rec.ev_code = ERR_RASTER_SHORT;
                end
                // restart for the next file
                n_phase = PH_HEADER;  n_pos = '0;  n_magic = '0;  n_planes = '0;
                n_bpp = '0;  n_offs = '0;  n_dib = '0;  n_iw = '0;  n_ih = '0;
                n_comp = '0;  n_colors = '0;  n_bu = 1'b1;  n_pcount = '0;
                n_pal_begin = '0;  n_pal_end = '0;  n_stride = '0;  n_row = '0;
                n_col = '0;  n_bir = '0;  n_cpart = '0;  n_pc = '0;  n_row_base = '0;
            end else if (r_pos != 32'hFFFF_FFFF) begin
                n_pos = 32'(r_pos + 32'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_base_top <= 21'(21'(11'(dh - 11'd1)) * 21'(dw[10:1]));
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;  r_pos <= '0;  r_magic <= '0;  r_planes <= '0;
            r_bpp <= '0;  r_offs <= '0;  r_dib <= '0;  r_iw <= '0;  r_ih <= '0;
            r_comp <= '0;  r_colors <= '0;  r_bu <= 1'b1;  r_pcount <= '0;
            r_pal_begin <= '0;  r_pal_end <= '0;  r_stride <= '0;  r_row <= '0;
            r_col <= '0;  r_bir <= '0;  r_cpart <= '0;  r_pc <= '0;  r_row_base <= '0;
            o_rec.valid <= 1'b0;
        end else begin
            r_phase <= n_phase;  r_pos <= n_pos;  r_magic <= n_magic;
            r_planes <= n_planes;  r_bpp <= n_bpp;  r_offs <= n_offs;  r_dib <= n_dib;
            r_iw <= n_iw;  r_ih <= n_ih;  r_comp <= n_comp;  r_colors <= n_colors;
            r_bu <= n_bu;  r_pcount <= n_pcount;  r_pal_begin <= n_pal_begin;
            r_pal_end <= n_pal_end;  r_stride <= n_stride;  r_row <= n_row;
            r_col <= n_col;  r_bir <= n_bir;  r_cpart <= n_cpart;  r_pc <= n_pc;
            r_row_base <= n_row_base;
            o_rec <= n_rec;
        end
    end

endmodule

// ===== sv/bmpg_gray.sv =====
module bmpg_gray (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bmpg_pkg::t_rec  i_rec,
    input  logic [23:0]     i_pal_rgb,
    output bmpg_pkg::t_push o_push
);
    import bmpg_pkg::*;

    typedef struct packed {
        logic        valid;
        logic        pix;
        logic        odd;
        logic [18:0] addr;
        logic        ev;
        t_kind       ev_kind;
        t_err        ev_code;
        logic [7:0]  y;
    } t_s2;

    t_s2         r_s2;
    logic [3:0]  r_pend;
    logic [23:0] rgb;
    logic [3:0]  g4;
    logic        emit;
    t_res        res_pix, res_ev;

    assign rgb = i_rec.is8 ? i_pal_rgb : i_rec.rgb;

    // luminance stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid   <= i_rec.valid;
            r_s2.pix     <= i_rec.pix;
            r_s2.odd     <= i_rec.odd;
            r_s2.addr    <= i_rec.addr;
            r_s2.ev      <= i_rec.ev;
            r_s2.ev_kind <= i_rec.ev_kind;
            r_s2.ev_code <= i_rec.ev_code;
            r_s2.y       <= luma(rgb[23:16], rgb[15:8], rgb[7:0]);
        end
    end

    // gray level, pairing and result assembly
    always_comb begin
        g4   = gray4(r_s2.y);
        emit = r_s2.valid && r_s2.pix && r_s2.odd;
        res_pix.kind         = KIND_PIXEL;
        res_pix.pixel_pair   = {r_pend, g4};
        res_pix.byte_address = r_s2.addr;
        res_pix.error_code   = ERR_NONE;
        res_pix.final_res    = !r_s2.ev;
        res_ev.kind          = r_s2.ev_kind;
        res_ev.pixel_pair    = 8'd0;
        res_ev.byte_address  = 19'd0;
        res_ev.error_code    = r_s2.ev_code;
        res_ev.final_res     = 1'b1;
        o_push.we0 = emit || (r_s2.valid && r_s2.ev);
        o_push.we1 = emit && r_s2.ev;
        o_push.d0  = emit ? res_pix : res_ev;
        o_push.d1  = res_ev;
    end

    // hold the left pixel of each pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 4'd0;
        end else if (r_s2.valid && r_s2.pix && !r_s2.odd) begin
            r_pend <= g4;
        end
    end

endmodule

// ===== sv/bmpg_fifo.sv =====
module bmpg_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bmpg_pkg::t_push               i_push,
    output logic                          o_valid,
    input  logic                          i_ready,
    output bmpg_pkg::t_res                o_data,
    output logic [bmpg_pkg::FIFO_CW-1:0]  o_count
);
    import bmpg_pkg::*;

    t_res               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wp, r_rp;
    logic [FIFO_CW-1:0] r_cnt;
    logic               pop;
    logic [1:0]         npush;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;
    assign pop     = o_valid && i_ready;
    assign npush   = 2'(i_push.we0) + 2'(i_push.we1);

    // store up to two results a cycle
    always_ff @(posedge i_clk) begin
        if (i_push.we0) r_mem[r_wp] <= i_push.d0;
        if (i_push.we1) r_mem[FIFO_AW'(r_wp + 1'b1)] <= i_push.d1;
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= FIFO_AW'(r_wp + FIFO_AW'(npush));
            r_rp  <= FIFO_AW'(r_rp + FIFO_AW'(pop));
            r_cnt <= FIFO_CW'(r_cnt + FIFO_CW'(npush) - FIFO_CW'(pop));
        end
    end

endmodule

// ===== tb/tb_bmp_to_gray4_stream_decoder.sv =====
module tb_bmp_to_gray4_stream_decoder;
    import bmpg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PH_HDR  = 0;
    localparam int PH_SKIP = 1;
    localparam int PH_PIX  = 2;
    localparam int PH_HOLD = 3;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    typedef struct {
        logic [15:0] magic;
        logic [31:0] offs;
        logic [31:0] dib;
        logic [31:0] w;
        logic [31:0] h;
        logic [15:0] planes;
        logic [15:0] bpp;
        logic [31:0] comp;
        logic [31:0] ncol;
        int          cut;
        int          extra;
    } t_file;

    typedef struct {
        logic [10:0] dw;
        logic [10:0] dh;
        t_file       f;
        t_kind       want_kind;
        t_err        want_code;
    } t_case;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in         i_data;
    logic        o_valid;
    logic        i_ready;
    t_res        o_data;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [10:0] i_cfg_data;

    bmp_to_gray4_stream_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // expected decoder output, oldest first
    t_res pending_res[$];
    int   mismatches = 0;
    int   idle_mode = IDLE_NONE;
    logic press_go = 1'b0;
    logic press_done = 1'b0;
    int   hold_left = 0;
    int   bytes_sent = 0;

    // decoder shadow state
    logic [10:0] disp_w, disp_h;
    logic [31:0] fpos, offs, dib, img_w, img_h, bpp, ncol, magic, planes, comp;
    int          phase;
    logic        rows_flipped;
    int unsigned pal_cnt;
    logic [23:0] pal_mem [256];
    longint      pal_lo, pal_hi;
    int unsigned stride, row, col, row_byte, cpart;
    logic [15:0] part_rgb;
    logic [3:0]  held_nib;
    t_kind       close_kind;
    t_err        close_code;

    task automatic report(input string what, input t_res got, input t_res want);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: got kind=%0d pair=%h addr=%0d err=%0d fin=%0d, want kind=%0d pair=%h addr=%0d err=%0d fin=%0d",
                     $time, what, got.kind, got.pixel_pair, got.byte_address, got.error_code,
                     got.final_res, want.kind, want.pixel_pair, want.byte_address,
                     want.error_code, want.final_res);
    endtask

    function automatic void post(t_kind k, logic [7:0] pr, logic [18:0] a, t_err c);
        t_res r;
        r.kind = k;
        r.pixel_pair = pr;
        r.byte_address = a;
        r.error_code = c;
        r.final_res = 1'b0;
        pending_res.push_back(r);
        if (k != KIND_PIXEL) begin
            close_kind = k;
            close_code = c;
        end
    endfunction

    function automatic void abort(t_err c);
        post(KIND_ERROR, 8'd0, 19'd0, c);
        phase = PH_HOLD;
    endfunction

    function automatic void restart_file();
        fpos = 0; phase = PH_HDR; offs = 0; dib = 0;
        img_w = 0; img_h = 0; bpp = 0; ncol = 0; magic = 0; planes = 0; comp = 0;
        rows_flipped = 1'b1; pal_cnt = 0; pal_lo = 0; pal_hi = 0; stride = 0;
        row = 0; col = 0; row_byte = 0; cpart = 0; part_rgb = 0; held_nib = 0;
    endfunction

    function automatic logic [31:0] grab(logic [31:0] f, int start, int n, logic [7:0] b);
        if (fpos >= start && fpos < start + n)
            f = f | (32'(b) << (8 * (fpos - start)));
        return f;
    endfunction

    function automatic logic display_bad();
        return disp_w == 0 || disp_w[0] || disp_w > MAX_WIDTH ||
               disp_h == 0 || disp_h > MAX_HEIGHT;
    endfunction

    // header checks in priority order
    function automatic void check_header();
        longint      o, d;
        int unsigned n;
        o = longint'(offs);
        d = longint'(dib);
        if (display_bad()) begin abort(ERR_DISPLAY); return; end
        if (magic != 32'(BMP_MAGIC)) begin abort(ERR_MAGIC); return; end
        if (o < 14 + d || dib < 40) begin abort(ERR_BAD_DIB); return; end
        if (img_w[31] || img_w == 0 || planes != 1 || (bpp != 8 && bpp != 24) ||
            comp != 0) begin
            abort(ERR_UNSUPPORTED); return;
        end
        if (img_h[31]) begin
            rows_flipped = 1'b0;
            img_h = ~img_h + 1;
        end else begin
            rows_flipped = img_h != 0;
        end
        pal_lo = 14 + d;
        pal_hi = pal_lo;
        if (bpp == 8) begin
            n = (ncol != 0) ? ncol : 256;
            if (n > PALETTE_ENTRIES) begin abort(ERR_PAL_LARGE); return; end
            pal_cnt = n;
            pal_hi = pal_lo + 4 * longint'(n);
            if (pal_hi > o) begin abort(ERR_PAL_OVERLAP); return; end
        end
        if (img_w != 32'(disp_w) || img_h != 32'(disp_h)) begin
            abort(ERR_SIZE); return;
        end
        stride = ((img_w * bpp + 31) / 32) * 4;
        phase = (offs == 54) ? PH_PIX : PH_SKIP;
    endfunction

    function automatic void shade(int unsigned r, int unsigned g, int unsigned b);
        int unsigned y, lvl, drow, addr;
        y = (77 * r + 150 * g + 29 * b) >> 8;
        lvl = (y * 15 + 127) / 255;
        if (col & 1) begin
            drow = rows_flipped ? img_h - 1 - row : row;
            addr = drow * (img_w / 2) + col / 2;
            post(KIND_PIXEL, {held_nib, lvl[3:0]}, addr[18:0], ERR_NONE);
        end else begin
            held_nib = lvl[3:0];
        end
        col++;
    endfunction

    function automatic void pixel_byte(logic [7:0] b);
        int unsigned idx;
        logic [23:0] c;
        if (bpp == 8) begin
            if (row_byte < img_w) begin
                idx = b;
                if (idx >= pal_cnt) idx = pal_cnt ? pal_cnt - 1 : 0;
                c = pal_mem[idx & 255];
                shade(c[23:16], c[15:8], c[7:0]);
            end
        end else if (row_byte < 3 * img_w) begin
            if (cpart == 0) begin
                part_rgb = {8'd0, b}; cpart = 1;
            end else if (cpart == 1) begin
                part_rgb[15:8] = b; cpart = 2;
            end else begin
                shade(b, part_rgb[15:8], part_rgb[7:0]);
                cpart = 0;
            end
        end
        row_byte++;
        if (row_byte >= stride) begin
            row_byte = 0; col = 0; cpart = 0;
            row++;
            if (row >= img_h) begin
                post(KIND_DONE, 8'd0, 19'd0, ERR_NONE);
                phase = PH_HOLD;
            end
        end
    endfunction

    // advance the shadow decoder by one transferred byte
    function automatic void predict_byte(logic [7:0] b, logic last);
        int     queued;
        longint p;
        int unsigned k, i;
        t_res   r;
        queued = pending_res.size();
        p = longint'(fpos);
        if (phase == PH_HDR) begin
            magic  = grab(magic, 0, 2, b);
            offs   = grab(offs, 10, 4, b);
            dib    = grab(dib, 14, 4, b);
            img_w  = grab(img_w, 18, 4, b);
            img_h  = grab(img_h, 22, 4, b);
            planes = grab(planes, 26, 2, b);
            bpp    = grab(bpp, 28, 2, b);
            comp   = grab(comp, 30, 4, b);
            ncol   = grab(ncol, 46, 4, b);
            if (fpos == 0 && display_bad()) abort(ERR_DISPLAY);
            else if (fpos == 53) check_header();
        end else if (phase == PH_SKIP) begin
            if (bpp == 8 && p >= pal_lo && p < pal_hi) begin
                k = 32'(p - pal_lo);
                i = (k >> 2) & 255;
                if ((k & 3) < 3) pal_mem[i][8 * (k & 3) +: 8] = b;
            end
            if (p + 1 == longint'(offs)) phase = PH_PIX;
        end else if (phase == PH_PIX) begin
            pixel_byte(b);
        end
        if (last) begin
            if (phase != PH_HOLD) begin
                if (phase == PH_HDR) abort(ERR_SHORT_HDR);
                else if (phase == PH_SKIP && bpp == 8 && p + 1 < pal_hi) abort(ERR_PAL_SHORT);
                else abort(ERR_RASTER_SHORT);
            end
            restart_file();
        end else if (fpos != 32'hFFFF_FFFF) begin
            fpos++;
        end
        if (pending_res.size() > queued) begin
            r = pending_res.pop_back();
            r.final_res = 1'b1;
            pending_res.push_back(r);
        end
    endfunction

    function automatic logic roll(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (press_go && !press_done) begin
            press_done <= 1'b1;
            hold_left <= 400;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (idle_mode == IDLE_RECV) begin
            i_ready <= !roll(51);
        end else if (idle_mode == IDLE_BOTH) begin
            i_ready <= !roll(14);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // compare each output transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_res.size() == 0) begin
                want = '0;
                report("unexpected result", o_data, want);
            end else begin
                want = pending_res.pop_front();
                if (o_data.kind !== want.kind || o_data.pixel_pair !== want.pixel_pair ||
                    o_data.byte_address !== want.byte_address ||
                    o_data.error_code !== want.error_code ||
                    o_data.final_res !== want.final_res)
                    report("result mismatch", o_data, want);
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        gap = 0;
        if (idle_mode == IDLE_SEND && roll(51)) gap = $urandom_range(1, 3);
        if (idle_mode == IDLE_BOTH && roll(14)) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{data_byte: b, last_byte: last};
        do @(posedge i_clk); while (!o_ready);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    // wait for the queue to drain, then write both display registers
    task automatic set_display(logic [10:0] w, logic [10:0] h);
        while (pending_res.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        disp_w = w;
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        disp_h = h;
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_file make_file(logic [31:0] w, logic [31:0] h, int b, int n, int gap);
        t_file f;
        f.magic = BMP_MAGIC; f.dib = 40; f.w = w; f.h = h; f.planes = 1;
        f.bpp = 16'(b); f.comp = 0; f.ncol = n; f.cut = 0; f.extra = 0;
        f.offs = 54 + ((b == 8) ? 4 * ((n != 0) ? n : 256) : 0) + gap;
        return f;
    endfunction

    function automatic int file_len(t_file f);
        int unsigned rows, wc, bc, st;
        rows = f.h[31] ? -f.h : f.h;
        if (rows > 1100) rows = 1100;
        wc = (f.w > 4096) ? 4 : f.w;
        bc = (f.bpp > 32) ? 32 : f.bpp;
        st = ((wc * bc + 31) / 32) * 4;
        if (f.cut > 0) return f.cut;
        return ((f.offs > 2000) ? 2000 : f.offs) + st * rows + f.extra;
    endfunction

    task automatic send_file(t_file f);
        logic [7:0] hb [54];
        int len;
        for (int p = 0; p < 54; p++) hb[p] = 8'($urandom);
        for (int k = 0; k < 4; k++) begin
            hb[10 + k] = f.offs[8 * k +: 8];
            hb[14 + k] = f.dib[8 * k +: 8];
            hb[18 + k] = f.w[8 * k +: 8];
            hb[22 + k] = f.h[8 * k +: 8];
            hb[30 + k] = f.comp[8 * k +: 8];
            hb[46 + k] = f.ncol[8 * k +: 8];
        end
        for (int k = 0; k < 2; k++) begin
            hb[k] = f.magic[8 * k +: 8];
            hb[26 + k] = f.planes[8 * k +: 8];
            hb[28 + k] = f.bpp[8 * k +: 8];
        end
        len = file_len(f);
        for (int p = 0; p < len; p++)
            send_byte((p < 54) ? hb[p] : 8'($urandom), p == len - 1);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly well-formed files with random content, some broken or noise
    task automatic random_file();
        t_file f;
        logic [10:0] dw, dh;
        int w, h, sel;
        w = 2 * $urandom_range(1, 8);
        h = $urandom_range(1, 6);
        f = make_file(w, roll(30) ? -h : h, roll(50) ? 8 : 24,
                      roll(10) ? 0 : $urandom_range(1, 24), roll(60) ? 0 : $urandom_range(1, 6));
        if (roll(20)) begin
            f.dib = $urandom_range(41, 60);
            f.offs = f.offs + f.dib - 40;
        end
        dw = 11'(w);
        dh = 11'(h);
        if (roll(25)) begin
            sel = $urandom_range(0, 12);
            unique case (sel)
                0: f.magic = 16'($urandom);
                1: f.dib = $urandom_range(0, 39);
                2: f.bpp = 16;
                3: f.comp = $urandom_range(1, 3);
                4: f.planes = 2;
                5: f.ncol = $urandom_range(257, 400);
                6: f.offs = $urandom_range(0, 60);
                7: dw = 11'(w + 2);
                8: dh = 11'(h + 1);
                9: f.cut = $urandom_range(1, file_len(f));
                10: f.extra = $urandom_range(1, 9);
                11: dw = 11'($urandom_range(0, 2047));
                default: begin
                    f.magic = 16'($urandom); f.offs = $urandom; f.w = $urandom;
                    f.cut = $urandom_range(1, 80);
                end
            endcase
        end
        if (dw != disp_w || dh != disp_h) set_display(dw, dh);
        send_file(f);
    endtask

    initial begin
        #30_000_000;
        $display("bmp_to_gray4_stream_decoder: mismatch");
        $finish;
    end

    initial begin
        t_case cases[$];
        t_case c;
        int    n;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_WIDTH;
        i_cfg_data = '0;
        disp_w = 0;
        disp_h = 0;
        for (int k = 0; k < 256; k++) pal_mem[k] = '0;
        restart_file();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed files: display setting, file layout, closing event
        c.want_kind = KIND_ERROR;
        c.dw = 0; c.dh = 0; c.f = make_file(4, 2, 24, 0, 0); c.f.cut = 1;
        c.want_code = ERR_DISPLAY; cases.push_back(c);
        c.dw = 3; c.dh = 2; cases.push_back(c);
        c.dw = 2046; cases.push_back(c);
        c.dw = 4; c.dh = 0; cases.push_back(c);
        c.dh = 1025; cases.push_back(c);
        c.dw = 2047; c.dh = 2047; cases.push_back(c);
        c.dw = 4; c.dh = 2;
        c.f = make_file(4, 2, 24, 0, 0); c.f.cut = 20;
        c.want_code = ERR_SHORT_HDR; cases.push_back(c);
        c.f = make_file(4, 2, 24, 0, 0); c.f.magic = 16'h4D43; c.f.cut = 54;
        c.want_code = ERR_MAGIC; cases.push_back(c);
        c.f = make_file(4, 2, 24, 0, 0); c.f.dib = 12; c.f.cut = 54;
        c.want_code = ERR_BAD_DIB; cases.push_back(c);
        c.f = make_file(4, 2, 24, 0, 0); c.f.bpp = 16; c.f.cut = 54;
        c.want_code = ERR_UNSUPPORTED; cases.push_back(c);
        c.f = make_file(4, 2, 24, 0, 0); c.f.comp = 1; c.f.cut = 54; cases.push_back(c);
        c.f = make_file(4, 2, 24, 0, 0); c.f.w = 32'h8000_0004; c.f.cut = 54;
        cases.push_back(c);
        c.f = make_file(4, 2, 8, 300, 0); c.f.offs = 54; c.f.cut = 54;
        c.want_code = ERR_PAL_LARGE; cases.push_back(c);
        c.f = make_file(4, 2, 8, 4, 0); c.f.offs = 62; c.f.cut = 54;
        c.want_code = ERR_PAL_OVERLAP; cases.push_back(c);
        c.f = make_file(4, 2, 8, 4, 2); c.f.cut = 60;
        c.want_code = ERR_PAL_SHORT; cases.push_back(c);
        c.f = make_file(6, 2, 24, 0, 0); c.f.cut = 54;
        c.want_code = ERR_SIZE; cases.push_back(c);
        c.f = make_file(4, 2, 24, 0, 0); c.f.cut = file_len(c.f) - 3;
        c.want_code = ERR_RASTER_SHORT; cases.push_back(c);
        c.f = make_file(4, 2, 24, 0, 0); c.f.cut = 54; cases.push_back(c);
        // largest display accepted, file ends at the header
        c.dw = 1024; c.dh = 1024; c.f = make_file(1024, 1024, 24, 0, 0); c.f.cut = 54;
        cases.push_back(c);
        c.dw = 4; c.dh = 2;
        c.want_kind = KIND_DONE; c.want_code = ERR_NONE;
        c.f = make_file(4, 2, 24, 0, 0); cases.push_back(c);
        c.f = make_file(4, -2, 24, 0, 0); cases.push_back(c);
        // two entries: most indices clamp to the last one
        c.f = make_file(4, 2, 8, 2, 0); cases.push_back(c);
        c.f = make_file(4, 2, 8, 3, 5); c.f.extra = 7; cases.push_back(c);

        foreach (cases[k]) begin
            idle_mode = k % 4;
            if (cases[k].dw != disp_w || cases[k].dh != disp_h)
                set_display(cases[k].dw, cases[k].dh);
            send_file(cases[k].f);
            if (close_kind != cases[k].want_kind || close_code != cases[k].want_code) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t file %0d closed with kind=%0d err=%0d, want kind=%0d err=%0d",
                             $time, k, close_kind, close_code, cases[k].want_kind,
                             cases[k].want_code);
            end
        end

        // random files; one long receiver hold-off early on
        n = 0;
        while (bytes_sent < 1250 || n < 3) begin
            idle_mode = n % 5;
            if (idle_mode > IDLE_BOTH) idle_mode = IDLE_NONE;
            if (n == 1) press_go <= 1'b1;
            random_file();
            n++;
        end

        while (pending_res.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_res.size() == 0)
            $display("bmp_to_gray4_stream_decoder: match");
        else
            $display("bmp_to_gray4_stream_decoder: mismatch");
        $finish;
    end

endmodule
